// File: sv/rpce_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the relocation patch command engine
// no dependencies

package rpce_pkg;

    // command codes carried in the top byte of a header word
    localparam logic [7:0] CMD_ADDR32     = 8'd1;
    localparam logic [7:0] CMD_ADDR16LO   = 8'd4;
    localparam logic [7:0] CMD_ADDR16HI   = 8'd5;
    localparam logic [7:0] CMD_ADDR16HA   = 8'd6;
    localparam logic [7:0] CMD_REL24      = 8'd10;
    localparam logic [7:0] CMD_WRITE32    = 8'd32;
    localparam logic [7:0] CMD_WRITE16    = 8'd33;
    localparam logic [7:0] CMD_WRITE8     = 8'd34;
    localparam logic [7:0] CMD_CONDPTR    = 8'd35;
    localparam logic [7:0] CMD_COND32     = 8'd36;
    localparam logic [7:0] CMD_COND16     = 8'd37;
    localparam logic [7:0] CMD_COND8      = 8'd38;
    localparam logic [7:0] CMD_BRANCH     = 8'd64;
    localparam logic [7:0] CMD_BRANCHLINK = 8'd65;

    // result kinds
    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_UNKNOWN = 2'd2;
    localparam logic [1:0] ACT_TRUNC   = 2'd3;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [23:0] ABS_MARKER  = 24'hFFFFFE;
    localparam logic [31:0] DELTA_MASK  = 32'h03FFFFFC;
    localparam logic [31:0] REL24_KEEP  = 32'hFC000003;
    localparam logic [31:0] BRANCH_OP   = 32'h48000000;
    localparam logic [31:0] BRANCH_LINK = 32'h48000001;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ABS    = 3'd1,
        PH_OP1    = 3'd2,
        PH_OP2    = 3'd3,
        PH_READ   = 3'd4
    } t_phase;

    typedef struct packed {
        logic        opcode;
        logic [31:0] word;
        logic        end_of_stream;
    } t_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic [1:0]  access_size;
    } t_result;

endpackage

// File: sv/rpce_in_stage.sv
`timescale 1ns / 1ps
// input register of the engine: holds one accepted item for the decode stage
// depends on rpce_pkg

module rpce_in_stage
    import rpce_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // room when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/rpce_exec.sv
`timescale 1ns / 1ps
// command decoder: phase machine, command state and result formation
// depends on rpce_pkg

module rpce_exec
    import rpce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic [31:0] i_text_base,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_command, n_command;
    logic [31:0] r_patch, n_patch;
    logic [31:0] r_operand, n_operand;
    logic [31:0] r_expected, n_expected;

    logic [31:0] w;
    logic        eos;
    logic [7:0]  hdr_cmd;
    logic        hdr_abs;
    logic [31:0] hdr_addr;
    logic [31:0] resolved;
    logic [31:0] op_value;
    logic [31:0] delta_op;
    logic [31:0] delta_rd;
    logic [15:0] ha_value;
    logic [31:0] rd_mask;

    function automatic logic f_known(input logic [7:0] c);
        logic k;
        unique case (c) inside
            CMD_ADDR32, CMD_ADDR16LO, CMD_ADDR16HI, CMD_ADDR16HA, CMD_REL24,
            CMD_WRITE32, CMD_WRITE16, CMD_WRITE8, CMD_CONDPTR, CMD_COND32,
            CMD_COND16, CMD_COND8, CMD_BRANCH, CMD_BRANCHLINK: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

    function automatic logic f_is_cond(input logic [7:0] c);
        return (c >= CMD_CONDPTR) && (c <= CMD_COND8);
    endfunction

    function automatic logic f_resolves(input logic [7:0] c);
        logic k;
        unique case (c) inside
            CMD_ADDR32, CMD_ADDR16LO, CMD_ADDR16HI, CMD_ADDR16HA, CMD_REL24,
            CMD_CONDPTR, CMD_BRANCH, CMD_BRANCHLINK: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] f_cond_size(input logic [7:0] c);
        logic [1:0] s;
        if (c == CMD_COND16) begin
            s = SZ_HALF;
        end else if (c == CMD_COND8) begin
            s = SZ_BYTE;
        end else begin
            s = SZ_WORD;
        end
        return s;
    endfunction

    assign w        = i_item.word;
    assign eos      = i_item.end_of_stream;
    assign hdr_cmd  = w[31:24];
    assign hdr_abs  = (w[23:0] == ABS_MARKER);
    assign hdr_addr = i_text_base + {8'd0, w[23:0]};
    assign resolved = w[31] ? w : (i_text_base + w);
    assign op_value = f_resolves(r_command) ? resolved : w;
    assign delta_op = (op_value - r_patch) & DELTA_MASK;
    assign delta_rd = (r_operand - r_patch) & DELTA_MASK;
    assign ha_value = op_value[31:16] + {15'd0, op_value[15]};
    assign rd_mask  = (r_command == CMD_COND16) ? 32'h0000FFFF :
                      (r_command == CMD_COND8)  ? 32'h000000FF : 32'hFFFFFFFF;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            if (i_item.opcode) begin
                if (r_phase == PH_READ) begin
                    n_phase = PH_HEADER;
                end
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (hdr_abs) begin
                            n_phase = eos ? PH_HEADER : PH_ABS;
                        end else if (!f_known(hdr_cmd) || eos) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase = PH_OP1;
                        end
                    end
                    PH_ABS: begin
                        n_phase = (!f_known(r_command) || eos) ? PH_HEADER : PH_OP1;
                    end
                    PH_OP1: begin
                        if (f_is_cond(r_command)) begin
                            n_phase = eos ? PH_HEADER : PH_OP2;
                        end else if (r_command == CMD_REL24) begin
                            n_phase = PH_READ;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end
                    PH_OP2:  n_phase = PH_READ;
                    PH_READ: n_phase = PH_READ;
                    default: n_phase = PH_HEADER;
                endcase
            end
        end
    end

    // command state and result
    always_comb begin
        n_command   = r_command;
        n_patch     = r_patch;
        n_operand   = r_operand;
        n_expected  = r_expected;
        o_res_valid = 1'b0;
        o_res       = '{action: ACT_WRITE, mem_address: r_patch, mem_data: 32'd0,
                        access_size: SZ_WORD};
        if (i_fire) begin
            if (i_item.opcode) begin
                if (r_phase == PH_READ) begin
                    if (r_command == CMD_REL24) begin
                        o_res_valid    = 1'b1;
                        o_res.mem_data = (w & REL24_KEEP) | delta_rd;
                    end else if (f_is_cond(r_command) &&
                                 ((w & rd_mask) == (r_expected & rd_mask))) begin
                        o_res_valid       = 1'b1;
                        o_res.mem_data    = r_operand & rd_mask;
                        o_res.access_size = f_cond_size(r_command);
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        n_command = hdr_cmd;
                        n_patch   = hdr_abs ? 32'd0 : hdr_addr;
                        o_res     = '{action: ACT_TRUNC, mem_address: n_patch,
                                      mem_data: {24'd0, hdr_cmd}, access_size: SZ_BYTE};
                        if (!hdr_abs && !f_known(hdr_cmd)) begin
                            o_res_valid  = 1'b1;
                            o_res.action = ACT_UNKNOWN;
                        end else begin
                            o_res_valid = eos;
                        end
                    end
                    PH_ABS: begin
                        n_patch = w;
                        o_res   = '{action: ACT_TRUNC, mem_address: w,
                                    mem_data: {24'd0, r_command}, access_size: SZ_BYTE};
                        if (!f_known(r_command)) begin
                            o_res_valid  = 1'b1;
                            o_res.action = ACT_UNKNOWN;
                        end else begin
                            o_res_valid = eos;
                        end
                    end
                    PH_OP1: begin
                        n_operand = op_value;
                        if (f_is_cond(r_command)) begin
                            o_res_valid = eos;
                            o_res = '{action: ACT_TRUNC, mem_address: r_patch,
                                      mem_data: {24'd0, r_command}, access_size: SZ_BYTE};
                        end else begin
                            o_res_valid = 1'b1;
                            unique case (r_command) inside
                                CMD_ADDR32, CMD_WRITE32: begin
                                    o_res.mem_data = op_value;
                                end
                                CMD_ADDR16LO, CMD_WRITE16: begin
                                    o_res.mem_data    = {16'd0, op_value[15:0]};
                                    o_res.access_size = SZ_HALF;
                                end
                                CMD_ADDR16HI: begin
                                    o_res.mem_data    = {16'd0, op_value[31:16]};
                                    o_res.access_size = SZ_HALF;
                                end
                                CMD_ADDR16HA: begin
                                    o_res.mem_data    = {16'd0, ha_value};
                                    o_res.access_size = SZ_HALF;
                                end
                                CMD_WRITE8: begin
                                    o_res.mem_data    = {24'd0, op_value[7:0]};
                                    o_res.access_size = SZ_BYTE;
                                end
                                CMD_REL24: begin
                                    o_res.action = ACT_READ;
                                end
                                CMD_BRANCH: begin
                                    o_res.mem_data = BRANCH_OP | delta_op;
                                end
                                CMD_BRANCHLINK: begin
                                    o_res.mem_data = BRANCH_LINK | delta_op;
                                end
                                default: begin
                                    o_res_valid = 1'b0;
                                end
                            endcase
                        end
                    end
                    PH_OP2: begin
                        n_expected        = w;
                        o_res_valid       = 1'b1;
                        o_res.action      = ACT_READ;
                        o_res.access_size = f_cond_size(r_command);
                    end
                    default: begin
                        o_res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_command  <= 8'd0;
            r_patch    <= 32'd0;
            r_operand  <= 32'd0;
            r_expected <= 32'd0;
        end else begin
            r_phase    <= n_phase;
            r_command  <= n_command;
            r_patch    <= n_patch;
            r_operand  <= n_operand;
            r_expected <= n_expected;
        end
    end

endmodule

// File: sv/relocation_patch_command_engine.sv
`timescale 1ns / 1ps
// top level of the relocation patch command engine: ports, text base register,
// result register; depends on rpce_pkg, rpce_in_stage and rpce_exec

// The engine takes one item per clock while the result side keeps up: command
// stream words (opcode 0) and memory read data coming back (opcode 1), and
// answers each with at most one result item - a memory write, a read request,
// an unknown command report or a truncated command report. An item is decoded
// against the command state while it sits in the input register, and its
// result is captured in the result register when the decode stage advances;
// items stream at one per cycle as long as the result side takes them. The
// rate is set by the single decode stage, where the phase machine, two 32-bit
// adds for relative addresses and two subtracts for branch and REL24
// displacements sit between the input and result registers. Read requests
// (REL24, conditional writes) expect the matching read data as a later input
// item; stream words arriving meanwhile are dropped. text_base may only be
// written while the engine is idle.

module relocation_patch_command_engine
    import rpce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [31:0] i_word,
    input  logic        i_end_of_stream,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_mem_data,
    output logic [1:0]  o_access_size
);

    logic [31:0] r_text_base;
    logic        r_out_valid;
    t_result     r_out;

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    advance;
    logic    fire;
    logic    res_valid;
    t_result res;

    // text base register, writes always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_base <= 32'd0;
        end else if (i_cfg_valid) begin
            r_text_base <= i_cfg_data;
        end
    end

    assign in_item = '{opcode: i_opcode, word: i_word, end_of_stream: i_end_of_stream};

    // the decode stage moves whenever the result register is free or being drained
    assign advance = !r_out_valid || i_out_ready;
    assign fire    = st_valid && advance;

    rpce_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    rpce_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (st_item),
        .i_text_base (r_text_base),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register; items that cause no result leave it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out.action;
    assign o_mem_address = r_out.mem_address;
    assign o_mem_data    = r_out.mem_data;
    assign o_access_size = r_out.access_size;

endmodule

// File: verif/rpce_patch_checker.sv
`timescale 1ns / 1ps
// result checker for the relocation patch command engine: watches all three channels,
// keeps its own copy of the command state and compares each result item field by field
// depends on rpce_pkg

module rpce_patch_checker
    import rpce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_opcode,
    input  logic [31:0] i_word,
    input  logic        i_end_of_stream,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_mem_address,
    input  logic [31:0] i_mem_data,
    input  logic [1:0]  i_access_size,
    output int          o_mismatches,
    output int          o_pending
);

    // mirrored engine state
    logic [31:0] text_base;
    t_phase      phase;
    logic [7:0]  command;
    logic [31:0] patch_address;
    logic [31:0] operand_value;
    logic [31:0] expected_original;

    t_result     expected_accesses[$];
    int          mismatch_count = 0;

    function automatic t_result make_access(input logic [1:0] act, input logic [31:0] addr,
                                            input logic [31:0] data, input logic [1:0] size);
        t_result r;
        r.action      = act;
        r.mem_address = addr;
        r.mem_data    = data;
        r.access_size = size;
        return r;
    endfunction

    function automatic bit is_cond(input logic [7:0] c);
        return (c >= CMD_CONDPTR) && (c <= CMD_COND8);
    endfunction

    function automatic logic [1:0] cond_size(input logic [7:0] c);
        if (c == CMD_COND16)
            return SZ_HALF;
        if (c == CMD_COND8)
            return SZ_BYTE;
        return SZ_WORD;
    endfunction

    // advance the mirrored state by one input item and work out its result, if any
    task automatic predict_patch(input logic is_data, input logic [31:0] w, input logic eos,
                                 output bit produced, output t_result res);
        logic [31:0] mask;
        logic [31:0] delta;
        bit          addr_known;
        bit          relative;
        produced   = 1'b0;
        res        = '0;
        addr_known = 1'b0;
        if (is_data) begin
            if (phase == PH_READ) begin
                phase = PH_HEADER;
                delta = (operand_value - patch_address) & DELTA_MASK;
                mask  = (command == CMD_COND16) ? 32'h0000FFFF :
                        (command == CMD_COND8)  ? 32'h000000FF : 32'hFFFFFFFF;
                if (command == CMD_REL24) begin
                    produced = 1'b1;
                    res = make_access(ACT_WRITE, patch_address, (w & REL24_KEEP) | delta,
                                      SZ_WORD);
                end else if (is_cond(command) && ((w & mask) == (expected_original & mask)))
                begin
                    produced = 1'b1;
                    res = make_access(ACT_WRITE, patch_address, operand_value & mask,
                                      cond_size(command));
                end
            end
        end else begin
            case (phase)
                PH_HEADER: begin
                    command = w[31:24];
                    if (w[23:0] == ABS_MARKER) begin
                        patch_address = '0;
                        phase         = PH_ABS;
                    end else begin
                        patch_address = text_base + {8'h00, w[23:0]};
                        addr_known    = 1'b1;
                    end
                end
                PH_ABS: begin
                    patch_address = w;
                    addr_known    = 1'b1;
                end
                PH_OP1: begin
                    case (command)
                        CMD_ADDR32, CMD_ADDR16LO, CMD_ADDR16HI, CMD_ADDR16HA, CMD_REL24,
                        CMD_CONDPTR, CMD_BRANCH, CMD_BRANCHLINK: relative = 1'b1;
                        default: relative = 1'b0;
                    endcase
                    operand_value = (relative && !w[31]) ? text_base + w : w;
                    if (is_cond(command)) begin
                        phase = PH_OP2;
                    end else begin
                        phase    = PH_HEADER;
                        delta    = (operand_value - patch_address) & DELTA_MASK;
                        produced = 1'b1;
                        case (command)
                            CMD_ADDR32, CMD_WRITE32:
                                res = make_access(ACT_WRITE, patch_address, operand_value,
                                                  SZ_WORD);
                            CMD_ADDR16LO, CMD_WRITE16:
                                res = make_access(ACT_WRITE, patch_address,
                                                  operand_value & 32'h0000FFFF, SZ_HALF);
                            CMD_ADDR16HI:
                                res = make_access(ACT_WRITE, patch_address,
                                                  {16'h0000, operand_value[31:16]}, SZ_HALF);
                            CMD_ADDR16HA:
                                // high half rounded up when the low half reads as negative
                                res = make_access(ACT_WRITE, patch_address,
                                                  ({16'h0000, operand_value[31:16]} +
                                                   {31'h0, operand_value[15]}) & 32'h0000FFFF,
                                                  SZ_HALF);
                            CMD_WRITE8:
                                res = make_access(ACT_WRITE, patch_address,
                                                  operand_value & 32'h000000FF, SZ_BYTE);
                            CMD_REL24: begin
                                phase = PH_READ;
                                res   = make_access(ACT_READ, patch_address, '0, SZ_WORD);
                            end
                            CMD_BRANCH:
                                res = make_access(ACT_WRITE, patch_address, BRANCH_OP | delta,
                                                  SZ_WORD);
                            CMD_BRANCHLINK:
                                res = make_access(ACT_WRITE, patch_address,
                                                  BRANCH_LINK | delta, SZ_WORD);
                            default: produced = 1'b0;
                        endcase
                    end
                end
                PH_OP2: begin
                    expected_original = w;
                    phase    = PH_READ;
                    produced = 1'b1;
                    res      = make_access(ACT_READ, patch_address, '0, cond_size(command));
                end
                PH_READ: ;
                default: phase = PH_HEADER;
            endcase
            // patch address settled: unknown codes are reported here
            if (addr_known) begin
                case (command)
                    CMD_ADDR32, CMD_ADDR16LO, CMD_ADDR16HI, CMD_ADDR16HA, CMD_REL24,
                    CMD_WRITE32, CMD_WRITE16, CMD_WRITE8, CMD_CONDPTR, CMD_COND32,
                    CMD_COND16, CMD_COND8, CMD_BRANCH, CMD_BRANCHLINK: phase = PH_OP1;
                    default: begin
                        phase    = PH_HEADER;
                        produced = 1'b1;
                        res = make_access(ACT_UNKNOWN, patch_address, {24'h0, command},
                                          SZ_BYTE);
                    end
                endcase
            end
            // stream flagged as ending with the command still open
            if (!produced && eos && (phase != PH_HEADER) && (phase != PH_READ)) begin
                phase    = PH_HEADER;
                produced = 1'b1;
                res = make_access(ACT_TRUNC, patch_address, {24'h0, command}, SZ_BYTE);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (seen !== want) begin
            $error("%s: expected %h, actual %h", name, want, seen);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        bit      produced;
        t_result fresh;
        t_result oldest;
        if (!i_rst_n) begin
            text_base         = '0;
            phase             = PH_HEADER;
            command           = '0;
            patch_address     = '0;
            operand_value     = '0;
            expected_original = '0;
            expected_accesses.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                text_base = i_cfg_data;
            // results leave only after their item has passed the input and result registers, so retire before adding
            if (i_out_valid && i_out_ready) begin
                if (expected_accesses.size() == 0) begin
                    $error("result item with none expected: action %0d address %h data %h",
                           i_action, i_mem_address, i_mem_data);
                    mismatch_count++;
                end else begin
                    oldest = expected_accesses.pop_front();
                    compare_field("action", {30'h0, oldest.action}, {30'h0, i_action});
                    compare_field("mem_address", oldest.mem_address, i_mem_address);
                    compare_field("mem_data", oldest.mem_data, i_mem_data);
                    compare_field("access_size", {30'h0, oldest.access_size},
                                  {30'h0, i_access_size});
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_patch(i_opcode, i_word, i_end_of_stream, produced, fresh);
                if (produced)
                    expected_accesses.push_back(fresh);
            end
        end
        o_pending    <= expected_accesses.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: verif/tb_relocation_patch_command_engine.sv
`timescale 1ns / 1ps
// testbench top for the relocation patch command engine: clock, reset, stimulus and verdict
// depends on rpce_pkg, rpce_patch_checker and relocation_patch_command_engine

module tb_relocation_patch_command_engine;
    import rpce_pkg::*;

    localparam int RANDOM_ITEMS   = 1450;
    localparam int N_PHASES       = 6;
    // engine answers through its input and result registers; leave margin for items with no result
    localparam int DRAIN_CYCLES   = 6;
    // longest correct quiet stretch is a stall burst plus the drain hold
    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        opcode        = 1'b0;
    logic [31:0] word          = '0;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b1;
    logic [1:0]  action;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic [1:0]  access_size;

    int          mismatches;
    int          pending;

    // idling switches, per phase of the run
    bit          send_idle     = 1'b0;
    bit          recv_idle     = 1'b0;

    int          items_sent    = 0;
    int          ignored_sent  = 0;
    int          results_seen  = 0;
    int          cfg_writes    = 0;
    int          idle_cycles   = 0;

    relocation_patch_command_engine uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_word          (word),
        .i_end_of_stream (end_of_stream),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_action        (action),
        .o_mem_address   (mem_address),
        .o_mem_data      (mem_data),
        .o_access_size   (access_size)
    );

    rpce_patch_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_word          (word),
        .i_end_of_stream (end_of_stream),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_action        (action),
        .i_mem_address   (mem_address),
        .i_mem_data      (mem_data),
        .i_access_size   (access_size),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // result side: random stall bursts while recv_idle is set
    initial begin
        forever begin
            @(negedge clk);
            if (recv_idle && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles where no item moves on any channel; also counts results
    always @(posedge clk) begin
        if (out_valid && out_ready)
            results_seen <= results_seen + 1;
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
            (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input item; valid stays up from the previous item unless a gap is taken
    task automatic send_item(input logic op, input logic [31:0] w, input logic eos);
        if (send_idle && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        word          <= w;
        end_of_stream <= eos;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // config writes only happen with the engine drained
    task automatic write_text_base(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending until every predicted result is out, then let the pipe empty
    task automatic settle_engine();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // addresses and operands, biased toward the corners
    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 9))
            0: return 32'h00000000;
            1: return 32'hFFFFFFFF;
            2: return 32'h80000000;
            3: return 32'h7FFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // one well-formed command with random content, optionally cut short by the
    // end-of-stream flag; read data follows where the command asks for it
    task automatic send_command(input logic [7:0] code, input bit absolute, input bit cut);
        logic [31:0] words[$];
        logic [31:0] low;
        logic [31:0] orig;
        logic [31:0] mask;
        logic [31:0] rd;
        int          n_ops;
        int          stop;
        int          k;
        bit          with_read;
        case (code)
            CMD_CONDPTR, CMD_COND32, CMD_COND16, CMD_COND8: n_ops = 2;
            CMD_ADDR32, CMD_ADDR16LO, CMD_ADDR16HI, CMD_ADDR16HA, CMD_REL24, CMD_WRITE32,
            CMD_WRITE16, CMD_WRITE8, CMD_BRANCH, CMD_BRANCHLINK: n_ops = 1;
            default: n_ops = 0;
        endcase
        with_read = (n_ops == 2) || (code == CMD_REL24);
        mask = (code == CMD_COND16) ? 32'h0000FFFF :
               (code == CMD_COND8)  ? 32'h000000FF : 32'hFFFFFFFF;
        low = pick_target();
        words.push_back({code, absolute ? ABS_MARKER : low[23:0]});
        if (absolute)
            words.push_back(pick_target());
        for (k = 0; k < n_ops; k++)
            words.push_back(pick_target());
        orig = words[words.size() - 1];
        // cut: end the stream on any word; otherwise flag the last word now and then
        stop = cut ? $urandom_range(0, words.size() - 1) : words.size() - 1;
        for (k = 0; k <= stop; k++)
            send_item(1'b0, words[k], (k == stop) && (cut || $urandom_range(0, 15) == 0));
        if (with_read && stop == words.size() - 1) begin
            // a stream word while the read is out gets dropped
            if ($urandom_range(0, 5) == 0)
                send_item(1'b0, $urandom, 1'($urandom_range(0, 1)));
            // mostly matching data so conditional writes go through
            rd = ($urandom_range(0, 2) != 0) ? ((orig & mask) | ($urandom & ~mask)) : $urandom;
            send_item(1'b1, rd, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_step();
        int          pick;
        logic [7:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
            // stray read data, normally ignored
            ignored_sent++;
            send_item(1'b1, $urandom, 1'($urandom_range(0, 1)));
        end else if (pick < 13) begin
            // raw word: knocks the command framing out of step
            send_item(1'b0, $urandom, $urandom_range(0, 7) == 0);
        end else if (pick < 14) begin
            settle_engine();
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                code = 8'($urandom);
            end else begin
                case ($urandom_range(0, 13))
                    0:  code = CMD_ADDR32;
                    1:  code = CMD_ADDR16LO;
                    2:  code = CMD_ADDR16HI;
                    3:  code = CMD_ADDR16HA;
                    4:  code = CMD_REL24;
                    5:  code = CMD_WRITE32;
                    6:  code = CMD_WRITE16;
                    7:  code = CMD_WRITE8;
                    8:  code = CMD_CONDPTR;
                    9:  code = CMD_COND32;
                    10: code = CMD_COND16;
                    11: code = CMD_COND8;
                    12: code = CMD_BRANCH;
                    default: code = CMD_BRANCHLINK;
                endcase
            end
            send_command(code, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin : stimulus
        int          p;
        int          goal;
        logic [31:0] base;

        // synchronous reset held low at the start, then released
        repeat (12) @(negedge clk);
        rst_n     <= 1'b1;
        send_idle <= 1'b1;
        recv_idle <= 1'b1;
        @(negedge clk);

        // base near the top so relative offsets wrap
        write_text_base(32'hFFFFFF00);

        // directed: corners and special cases
        // largest relative offset wraps; absolute operand
        send_item(1'b0, {CMD_ADDR32, 24'hFFFFFF}, 1'b0);
        send_item(1'b0, 32'hFFFFFFFF, 1'b0);
        // absolute header at address zero, branch to relative offset zero (the text base)
        send_item(1'b0, {CMD_BRANCH, ABS_MARKER}, 1'b0);
        send_item(1'b0, 32'h00000000, 1'b0);
        send_item(1'b0, 32'h00000000, 1'b0);
        // unknown code on a relative header reports at once
        send_item(1'b0, {8'hFF, 24'h000000}, 1'b0);
        // unknown code behind an absolute header reports after the address word
        send_item(1'b0, {8'h00, ABS_MARKER}, 1'b0);
        send_item(1'b0, 32'hFFFFFFFF, 1'b0);
        // stream ends right after a relative header
        send_item(1'b0, {CMD_WRITE32, 24'h000003}, 1'b1);
        // stream ends right after an absolute header: address reads as zero
        send_item(1'b0, {CMD_COND8, ABS_MARKER}, 1'b1);
        // conditional halfword: word during the read is dropped, then data matches
        send_item(1'b0, {CMD_COND16, 24'h000101}, 1'b0);
        send_item(1'b0, 32'h1234ABCD, 1'b0);
        send_item(1'b0, 32'h5555BEEF, 1'b0);
        send_item(1'b0, 32'hFFFFFFFF, 1'b1);
        send_item(1'b1, 32'hAAAABEEF, 1'b0);
        // read data with nothing outstanding
        send_item(1'b1, 32'h00000000, 1'b1);
        // conditional word that does not match: no write
        send_item(1'b0, {CMD_COND32, 24'h000000}, 1'b0);
        send_item(1'b0, 32'h80000000, 1'b0);
        send_item(1'b0, 32'h7FFFFFFF, 1'b0);
        send_item(1'b1, 32'h7FFFFFFE, 1'b0);
        // rel24 whose operand also carries the end flag: completes normally
        send_item(1'b0, {CMD_REL24, 24'h000010}, 1'b0);
        send_item(1'b0, 32'h00000004, 1'b1);
        send_item(1'b1, 32'hFFFFFFFF, 1'b0);

        // random phases, each under its own text_base; last phase runs without idling
        for (p = 0; p < N_PHASES; p++) begin
            settle_engine();
            case (p)
                0: base = 32'h00000000;
                1: base = 32'hFFFFFFFF;
                2: base = 32'h80000000;
                3: base = 32'h7FFFFFFC;
                default: base = $urandom;
            endcase
            send_idle <= (p != N_PHASES - 1) && (p % 3 != 2);
            recv_idle <= (p != N_PHASES - 1) && (p % 3 != 1);
            write_text_base(base);
            goal = items_sent + RANDOM_ITEMS / N_PHASES;
            while (items_sent < goal)
                random_step();
        end

        // drain: everything predicted must arrive, then watch for strays
        settle_engine();
        $display("run covered %0d input items (%0d stray read data), %0d result items, %0d text_base settings",
                 items_sent, ignored_sent, results_seen, cfg_writes);
        $display("all command codes, cut-off and unknown commands, idle bursts both sides");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
sv/rpce_pkg.sv
sv/rpce_in_stage.sv
sv/rpce_exec.sv
sv/relocation_patch_command_engine.sv
verif/rpce_patch_checker.sv
verif/tb_relocation_patch_command_engine.sv
